/* sv/cofr_pkg.sv */
// shared types, constants and octant mapping for the circle outline and fill rasterizer
package cofr_pkg;

    localparam int COORD_W    = 8;
    localparam int RADIUS_W   = 8;
    localparam int COLOR_W    = 16;
    localparam int OFFSET_W   = 10;
    localparam int DECISION_W = 12;
    localparam int POINT_W    = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int POINT_IDX_W = 3;

    localparam int MAX_RADIUS_DEF = 255;

    localparam logic [COORD_W-1:0] COLUMNS_RESET = 8'd162;
    localparam logic [COORD_W-1:0] LINES_RESET   = 8'd132;

    localparam logic [POINT_IDX_W-1:0] LAST_POINT = 3'd7;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINES   = 2'd1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_OUTLINE = 2'd1,
        PH_FILL    = 2'd2
    } phase_t;

    typedef logic signed [OFFSET_W-1:0]   offset_t;
    typedef logic signed [DECISION_W-1:0] decision_t;
    typedef logic signed [POINT_W-1:0]    point_t;

    // midpoint loop variables
    typedef struct packed {
        offset_t   x;
        offset_t   y;
        decision_t d;
    } loop_t;

    // how one of the eight mirrored points is formed from (a, b)
    typedef struct packed {
        logic swap;
        logic neg_x;
        logic neg_y;
    } octant_t;

    function automatic octant_t octant_map(input logic [POINT_IDX_W-1:0] k);
        octant_t o;
        o.swap  = (k == 3'd2) || (k == 3'd3) || (k == 3'd6) || (k == 3'd7);
        o.neg_x = (k == 3'd1) || (k == 3'd2) || (k == 3'd3) || (k == 3'd4);
        o.neg_y = (k == 3'd3) || (k == 3'd4) || (k == 3'd5) || (k == 3'd6);
        return o;
    endfunction

endpackage

/* sv/circle_outline_fill_rasterizer.sv */
// midpoint circle rasterizer with outline and optional fill pass, top level
// A start beat (command 0) loads center, radius, colors and fill flag and gives
// no result; a start whose center column exceeds columns or whose center row is at least lines
// leaves the block idle. Each step beat (command 1) advances the circle state in the cycle it
// is taken (one midpoint iteration in the outline pass; one span position in the fill pass,
// with an iteration once the span is done) and hands its eight mirrored points to the output,
// one beat per cycle while out_ready is high; a step while idle gives a single all-zero beat
// with last_of_step and done_res set. The output stage holds one step at a time: the next item
// is taken in the same cycle the final point of the current step leaves.
// After the outline, with the fill flag set and a radius of at least one, the fill pass reruns
// the loop on radius minus one and gives eight points per span position in the fill color.
// Clipped points come out with visible 0 and zero coordinates but keep their color.
module circle_outline_fill_rasterizer #(
    parameter int MAX_RADIUS = cofr_pkg::MAX_RADIUS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cofr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cofr_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic [cofr_pkg::COORD_W-1:0]         center_x,
    input  logic [cofr_pkg::COORD_W-1:0]         center_y,
    input  logic [cofr_pkg::RADIUS_W-1:0]        radius,
    input  logic [cofr_pkg::COLOR_W-1:0]         line_color,
    input  logic [cofr_pkg::COLOR_W-1:0]         fill_color,
    input  logic                                 fill_enable,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [cofr_pkg::COORD_W-1:0]         pixel_x,
    output logic [cofr_pkg::COORD_W-1:0]         pixel_y,
    output logic [cofr_pkg::COLOR_W-1:0]         pixel_color,
    output logic                                 visible,
    output logic                                 last_of_step,
    output logic                                 done_res
);

    // radius cap, clamped to what the radius field can carry
    localparam int RAD_FIELD_MAX = (2 ** cofr_pkg::RADIUS_W) - 1;
    localparam int RAD_CAP       = (MAX_RADIUS > RAD_FIELD_MAX) ? RAD_FIELD_MAX : MAX_RADIUS;
    localparam logic [cofr_pkg::RADIUS_W-1:0] RAD_LIMIT = cofr_pkg::RADIUS_W'(RAD_CAP);

    // clip bounds
    logic [cofr_pkg::COORD_W-1:0] columns_reg;
    logic [cofr_pkg::COORD_W-1:0] lines_reg;

    // circle state
    cofr_pkg::phase_t             phase_reg, phase_next;
    logic [cofr_pkg::COORD_W-1:0] center_col_reg, center_col_next;
    logic [cofr_pkg::COORD_W-1:0] center_row_reg, center_row_next;
    cofr_pkg::offset_t            offset_x_reg, offset_x_next;
    cofr_pkg::offset_t            offset_y_reg, offset_y_next;
    cofr_pkg::offset_t            span_pos_reg, span_pos_next;
    cofr_pkg::decision_t          decision_reg, decision_next;
    logic [cofr_pkg::RADIUS_W-1:0] saved_radius_reg, saved_radius_next;
    logic [cofr_pkg::COLOR_W-1:0] saved_line_color_reg, saved_line_color_next;
    logic [cofr_pkg::COLOR_W-1:0] saved_fill_color_reg, saved_fill_color_next;
    logic                         saved_fill_flag_reg, saved_fill_flag_next;

    // output stage: snapshot of one step, walked point by point
    logic                             em_busy_reg, em_busy_next;
    logic [cofr_pkg::POINT_IDX_W-1:0] em_idx_reg, em_idx_next;
    logic                             em_idle_reg, em_idle_next;
    logic                             em_done_reg, em_done_next;
    logic [cofr_pkg::COORD_W-1:0]     em_cx_reg, em_cx_next;
    logic [cofr_pkg::COORD_W-1:0]     em_cy_reg, em_cy_next;
    cofr_pkg::offset_t                em_a_reg, em_a_next;
    cofr_pkg::offset_t                em_b_reg, em_b_next;
    logic [cofr_pkg::COLOR_W-1:0]     em_color_reg, em_color_next;

    logic in_fire;
    logic out_fire;
    logic out_last;
    logic step_fire;

    // one midpoint iteration
    function automatic cofr_pkg::loop_t advance(input cofr_pkg::offset_t x,
                                                input cofr_pkg::offset_t y,
                                                input cofr_pkg::decision_t d);
        cofr_pkg::loop_t   l;
        cofr_pkg::decision_t dx;
        cofr_pkg::decision_t dy;
        dx = cofr_pkg::DECISION_W'(x);
        dy = cofr_pkg::DECISION_W'(y);
        if (d < 0)
        begin
            l.d = d + (dx <<< 2) + 12'sd6;
            l.y = y;
        end
        else
        begin
            l.d = d + ((dx - dy) <<< 2) + 12'sd10;
            l.y = y - 10'sd1;
        end
        l.x = x + 10'sd1;
        return l;
    endfunction

    // loop start for radius r
    function automatic cofr_pkg::loop_t loop_init(input logic [cofr_pkg::RADIUS_W-1:0] r);
        cofr_pkg::loop_t l;
        l.x = '0;
        l.y = cofr_pkg::OFFSET_W'({1'b0, r});
        l.d = 12'sd3 - (cofr_pkg::DECISION_W'({1'b0, r}) <<< 1);
        return l;
    endfunction

    assign cfg_ready = 1'b1;

    // a new item may enter once the current step has shown its final point
    assign out_valid = em_busy_reg;
    assign out_last  = em_idle_reg || (em_idx_reg == cofr_pkg::LAST_POINT);
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = !em_busy_reg || (out_last && out_ready);
    assign in_fire   = in_valid && in_ready;
    assign step_fire = in_fire && (command == cofr_pkg::CMD_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= cofr_pkg::COLUMNS_RESET;
            lines_reg   <= cofr_pkg::LINES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == cofr_pkg::REG_COLUMNS)
            begin
                columns_reg <= cfg_data;
            end
            else if (cfg_index == cofr_pkg::REG_LINES)
            begin
                lines_reg <= cfg_data;
            end
        end
    end

    // next state of the circle and of the output stage
    always_comb
    begin
        cofr_pkg::loop_t               adv;
        cofr_pkg::loop_t               init;
        cofr_pkg::offset_t             span_inc;
        logic [cofr_pkg::RADIUS_W-1:0] r_sat;

        phase_next            = phase_reg;
        center_col_next       = center_col_reg;
        center_row_next       = center_row_reg;
        offset_x_next         = offset_x_reg;
        offset_y_next         = offset_y_reg;
        span_pos_next         = span_pos_reg;
        decision_next         = decision_reg;
        saved_radius_next     = saved_radius_reg;
        saved_line_color_next = saved_line_color_reg;
        saved_fill_color_next = saved_fill_color_reg;
        saved_fill_flag_next  = saved_fill_flag_reg;

        em_busy_next  = em_busy_reg;
        em_idx_next   = em_idx_reg;
        em_idle_next  = em_idle_reg;
        em_done_next  = em_done_reg;
        em_cx_next    = em_cx_reg;
        em_cy_next    = em_cy_reg;
        em_a_next     = em_a_reg;
        em_b_next     = em_b_reg;
        em_color_next = em_color_reg;

        adv      = advance(offset_x_reg, offset_y_reg, decision_reg);
        init     = loop_init(saved_radius_reg - 8'd1);
        span_inc = span_pos_reg + 10'sd1;
        r_sat    = (radius > RAD_LIMIT) ? RAD_LIMIT : radius;

        // walk the points of the current step
        if (out_fire)
        begin
            if (out_last)
            begin
                em_busy_next = 1'b0;
            end
            else
            begin
                em_idx_next = em_idx_reg + 3'd1;
            end
        end

        if (in_fire && (command == cofr_pkg::CMD_START))
        begin
            center_col_next       = center_x;
            center_row_next       = center_y;
            saved_radius_next     = r_sat;
            saved_line_color_next = line_color;
            saved_fill_color_next = fill_color;
            saved_fill_flag_next  = fill_enable;
            if ((center_x > columns_reg) || (center_y >= lines_reg))
            begin
                phase_next = cofr_pkg::PH_IDLE;
            end
            else
            begin
                init          = loop_init(r_sat);
                offset_x_next = init.x;
                offset_y_next = init.y;
                span_pos_next = '0;
                decision_next = init.d;
                phase_next    = cofr_pkg::PH_OUTLINE;
            end
        end
        else if (step_fire)
        begin
            em_busy_next = 1'b1;
            em_idx_next  = '0;
            em_cx_next   = center_col_reg;
            em_cy_next   = center_row_reg;
            em_idle_next = 1'b0;
            unique case (phase_reg)
                cofr_pkg::PH_OUTLINE:
                begin
                    em_a_next     = offset_x_reg;
                    em_b_next     = offset_y_reg;
                    em_color_next = saved_line_color_reg;
                    offset_x_next = adv.x;
                    offset_y_next = adv.y;
                    decision_next = adv.d;
                    if (adv.x > adv.y)
                    begin
                        if (saved_fill_flag_reg && (saved_radius_reg != '0))
                        begin
                            offset_x_next = init.x;
                            offset_y_next = init.y;
                            span_pos_next = '0;
                            decision_next = init.d;
                            phase_next    = cofr_pkg::PH_FILL;
                        end
                        else
                        begin
                            phase_next = cofr_pkg::PH_IDLE;
                        end
                    end
                end
                cofr_pkg::PH_FILL:
                begin
                    em_a_next     = offset_x_reg;
                    em_b_next     = span_pos_reg;
                    em_color_next = saved_fill_color_reg;
                    span_pos_next = span_inc;
                    if (span_inc > offset_y_reg)
                    begin
                        offset_x_next = adv.x;
                        offset_y_next = adv.y;
                        decision_next = adv.d;
                        span_pos_next = adv.x;
                        if (adv.x > adv.y)
                        begin
                            phase_next = cofr_pkg::PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    // idle step: one blank beat
                    em_idle_next  = 1'b1;
                    em_a_next     = '0;
                    em_b_next     = '0;
                    em_color_next = '0;
                end
            endcase
            em_done_next = (phase_next == cofr_pkg::PH_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= cofr_pkg::PH_IDLE;
            center_col_reg       <= '0;
            center_row_reg       <= '0;
            offset_x_reg         <= '0;
            offset_y_reg         <= '0;
            span_pos_reg         <= '0;
            decision_reg         <= '0;
            saved_radius_reg     <= '0;
            saved_line_color_reg <= '0;
            saved_fill_color_reg <= '0;
            saved_fill_flag_reg  <= 1'b0;
            em_busy_reg          <= 1'b0;
            em_idx_reg           <= '0;
            em_idle_reg          <= 1'b0;
            em_done_reg          <= 1'b0;
        end
        else
        begin
            phase_reg            <= phase_next;
            center_col_reg       <= center_col_next;
            center_row_reg       <= center_row_next;
            offset_x_reg         <= offset_x_next;
            offset_y_reg         <= offset_y_next;
            span_pos_reg         <= span_pos_next;
            decision_reg         <= decision_next;
            saved_radius_reg     <= saved_radius_next;
            saved_line_color_reg <= saved_line_color_next;
            saved_fill_color_reg <= saved_fill_color_next;
            saved_fill_flag_reg  <= saved_fill_flag_next;
            em_busy_reg          <= em_busy_next;
            em_idx_reg           <= em_idx_next;
            em_idle_reg          <= em_idle_next;
            em_done_reg          <= em_done_next;
        end
    end

    // step snapshot payload, no reset needed
    always_ff @(posedge clk)
    begin
        em_cx_reg    <= em_cx_next;
        em_cy_reg    <= em_cy_next;
        em_a_reg     <= em_a_next;
        em_b_reg     <= em_b_next;
        em_color_reg <= em_color_next;
    end

    // mirror the snapshot into the current point and clip it
    always_comb
    begin
        cofr_pkg::octant_t oct;
        cofr_pkg::point_t  u;
        cofr_pkg::point_t  v;
        cofr_pkg::point_t  px;
        cofr_pkg::point_t  py;
        logic              vis;

        oct = cofr_pkg::octant_map(em_idx_reg);
        u   = oct.swap ? cofr_pkg::POINT_W'(em_b_reg) : cofr_pkg::POINT_W'(em_a_reg);
        v   = oct.swap ? cofr_pkg::POINT_W'(em_a_reg) : cofr_pkg::POINT_W'(em_b_reg);
        px  = $signed({3'b000, em_cx_reg}) + (oct.neg_x ? -u : u);
        py  = $signed({3'b000, em_cy_reg}) + (oct.neg_y ? -v : v);
        vis = (px >= 0) && (py >= 0)
              && (px <= $signed({3'b000, columns_reg}))
              && (py <= $signed({3'b000, lines_reg}))
              && !em_idle_reg;

        pixel_x      = vis ? px[cofr_pkg::COORD_W-1:0] : '0;
        pixel_y      = vis ? py[cofr_pkg::COORD_W-1:0] : '0;
        pixel_color  = em_color_reg;
        visible      = vis;
        last_of_step = out_last;
        done_res     = em_done_reg || em_idle_reg;
    end

endmodule

/* sv/cofr_checker.sv */
// port-level checker for the circle rasterizer and its bind
module cofr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             command,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [cofr_pkg::COORD_W-1:0]     pixel_x,
    input logic [cofr_pkg::COORD_W-1:0]     pixel_y,
    input logic [cofr_pkg::COLOR_W-1:0]     pixel_color,
    input logic                             visible,
    input logic                             last_of_step,
    input logic                             done_res
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_color) && $stable(visible) && $stable(last_of_step)
            && $stable(done_res))
        else $error("stalled result beat changed");

    // a step shows its first point in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == cofr_pkg::CMD_STEP) |=> out_valid)
        else $error("step gave no result beat");

    // points of one step follow without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_step |=> out_valid)
        else $error("gap inside a step");

    // no new item while a step still has points to give
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_step |-> !in_ready)
        else $error("item taken in the middle of a step");

endmodule

bind circle_outline_fill_rasterizer cofr_checker u_cofr_checker (.*);

/* verif/circle_outline_fill_rasterizer_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for the midpoint circle outline and fill rasterizer
module circle_outline_fill_rasterizer_test;

    // cycles after the last result before a register write, start beats give no result
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 16;
    // longest legal quiet stretch is the deliberate hold-off plus a long random stall
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic                         cmd;
        logic [cofr_pkg::COORD_W-1:0] cx;
        logic [cofr_pkg::COORD_W-1:0] cy;
        logic [cofr_pkg::RADIUS_W-1:0] r;
        logic [cofr_pkg::COLOR_W-1:0] lc;
        logic [cofr_pkg::COLOR_W-1:0] fc;
        logic                         fe;
    } circle_cmd_t;

    localparam int CMD_BITS = $bits(circle_cmd_t);

    typedef struct packed {
        logic [cofr_pkg::COORD_W-1:0] x;
        logic [cofr_pkg::COORD_W-1:0] y;
        logic [cofr_pkg::COLOR_W-1:0] color;
        logic                         is_visible;
        logic                         is_last;
        logic                         is_done;
    } pixel_beat_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [cofr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [cofr_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic                             command;
    logic [cofr_pkg::COORD_W-1:0]     center_x;
    logic [cofr_pkg::COORD_W-1:0]     center_y;
    logic [cofr_pkg::RADIUS_W-1:0]    radius;
    logic [cofr_pkg::COLOR_W-1:0]     line_color;
    logic [cofr_pkg::COLOR_W-1:0]     fill_color;
    logic                             fill_enable;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [cofr_pkg::COORD_W-1:0]     pixel_x;
    logic [cofr_pkg::COORD_W-1:0]     pixel_y;
    logic [cofr_pkg::COLOR_W-1:0]     pixel_color;
    logic                             visible;
    logic                             last_of_step;
    logic                             done_res;

    circle_outline_fill_rasterizer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .line_color   (line_color),
        .fill_color   (fill_color),
        .fill_enable  (fill_enable),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_color  (pixel_color),
        .visible      (visible),
        .last_of_step (last_of_step),
        .done_res     (done_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // rasterizer shadow state, updated at every accepted beat
    // ---------------------------------------------------------------
    int                           bound_cols = int'(cofr_pkg::COLUMNS_RESET);
    int                           bound_lines = int'(cofr_pkg::LINES_RESET);
    cofr_pkg::phase_t             trace_phase = cofr_pkg::PH_IDLE;
    int                           ctr_col = 0;
    int                           ctr_row = 0;
    int                           off_x = 0;
    int                           off_y = 0;
    int                           fill_span = 0;
    int                           dec_term = 0;
    int                           keep_radius = 0;
    logic [cofr_pkg::COLOR_W-1:0] keep_line_color = '0;
    logic [cofr_pkg::COLOR_W-1:0] keep_fill_color = '0;
    logic                         keep_fill = 1'b0;

    pixel_beat_t pending_pixels[$];

    int items_sent = 0;
    int mismatch_count = 0;
    int send_gap_pct = 26;
    int stall_pct = 84;
    int hold_off_requests = 0;
    int hold_off_taken = 0;
    int hold_off_left = 0;
    int quiet_cycles = 0;

    // one midpoint iteration on the shadow loop variables
    function automatic void step_decision();
        if (dec_term < 0)
            dec_term += 4 * off_x + 6;
        else
        begin
            dec_term += 4 * (off_x - off_y) + 10;
            off_y--;
        end
        off_x++;
    endfunction

    function automatic void restart_loop(int r);
        off_x = 0;
        off_y = r;
        fill_span = 0;
        dec_term = 3 - 2 * r;
    endfunction

    // queue the eight mirrored points of (a, b), clipped against the bounds
    function automatic void push_mirrored(int a, int b, logic [cofr_pkg::COLOR_W-1:0] color,
                                          logic fin);
        int px [8];
        int py [8];
        pixel_beat_t p;
        px = '{ctr_col + a, ctr_col - a, ctr_col - b, ctr_col - b,
               ctr_col - a, ctr_col + a, ctr_col + b, ctr_col + b};
        py = '{ctr_row + b, ctr_row + b, ctr_row + a, ctr_row - a,
               ctr_row - b, ctr_row - b, ctr_row - a, ctr_row + a};
        for (int k = 0; k < 8; k++)
        begin
            p.is_visible = px[k] >= 0 && py[k] >= 0 && px[k] <= bound_cols && py[k] <= bound_lines;
            p.x = p.is_visible ? px[k][cofr_pkg::COORD_W-1:0] : '0;
            p.y = p.is_visible ? py[k][cofr_pkg::COORD_W-1:0] : '0;
            p.color = color;
            p.is_last = (k == int'(cofr_pkg::LAST_POINT));
            p.is_done = fin;
            pending_pixels.push_back(p);
        end
    endfunction

    // expected pixels for one accepted beat
    function automatic void trace_circle(circle_cmd_t it);
        int r;
        int a;
        int b;
        logic [cofr_pkg::COLOR_W-1:0] color;
        pixel_beat_t p;
        if (it.cmd == cofr_pkg::CMD_START)
        begin
            r = int'(it.r);
            if (r > cofr_pkg::MAX_RADIUS_DEF)
                r = cofr_pkg::MAX_RADIUS_DEF;
            ctr_col = int'(it.cx);
            ctr_row = int'(it.cy);
            keep_radius = r;
            keep_line_color = it.lc;
            keep_fill_color = it.fc;
            keep_fill = it.fe;
            // note the asymmetric check: column bound inclusive, row bound exclusive
            if (int'(it.cx) > bound_cols || int'(it.cy) >= bound_lines)
                trace_phase = cofr_pkg::PH_IDLE;
            else
            begin
                restart_loop(r);
                trace_phase = cofr_pkg::PH_OUTLINE;
            end
            return;
        end
        if (trace_phase == cofr_pkg::PH_OUTLINE)
        begin
            a = off_x;
            b = off_y;
            color = keep_line_color;
            step_decision();
            if (off_x > off_y)
            begin
                if (keep_fill && keep_radius >= 1)
                begin
                    restart_loop(keep_radius - 1);
                    trace_phase = cofr_pkg::PH_FILL;
                end
                else
                    trace_phase = cofr_pkg::PH_IDLE;
            end
        end
        else if (trace_phase == cofr_pkg::PH_FILL)
        begin
            a = off_x;
            b = fill_span;
            color = keep_fill_color;
            fill_span++;
            if (fill_span > off_y)
            begin
                step_decision();
                fill_span = off_x;
                if (off_x > off_y)
                    trace_phase = cofr_pkg::PH_IDLE;
            end
        end
        else
        begin
            // step with nothing active: a single blank beat
            p = '0;
            p.is_last = 1'b1;
            p.is_done = 1'b1;
            pending_pixels.push_back(p);
            return;
        end
        push_mirrored(a, b, color, trace_phase == cofr_pkg::PH_IDLE);
    endfunction

    // ---------------------------------------------------------------
    // result side: ready generation, checker, watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_taken != hold_off_requests)
        begin
            hold_off_taken = hold_off_requests;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        pixel_beat_t want;
        pixel_beat_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.x = pixel_x;
            got.y = pixel_y;
            got.color = pixel_color;
            got.is_visible = visible;
            got.is_last = last_of_step;
            got.is_done = done_res;
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected pixel beat: x=%0d y=%0d color=%h vis=%b last=%b done=%b",
                             got.x, got.y, got.color, got.is_visible, got.is_last, got.is_done);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("pixel mismatch at %0t", $realtime);
                        $display("  expected x=%0d y=%0d color=%h vis=%b last=%b done=%b",
                                 want.x, want.y, want.color, want.is_visible, want.is_last,
                                 want.is_done);
                        $display("  actual   x=%0d y=%0d color=%h vis=%b last=%b done=%b",
                                 got.x, got.y, got.color, got.is_visible, got.is_last,
                                 got.is_done);
                    end
                end
            end
        end
    end

    // any beat on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic send_item(circle_cmd_t it);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= it.cmd;
        center_x <= it.cx;
        center_y <= it.cy;
        radius <= it.r;
        line_color <= it.lc;
        fill_color <= it.fc;
        fill_enable <= it.fe;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        trace_circle(it);
        items_sent++;
    endtask

    task automatic send_start(logic [cofr_pkg::COORD_W-1:0] cx,
                              logic [cofr_pkg::COORD_W-1:0] cy,
                              logic [cofr_pkg::RADIUS_W-1:0] r,
                              logic [cofr_pkg::COLOR_W-1:0] lc,
                              logic [cofr_pkg::COLOR_W-1:0] fc, logic fe);
        circle_cmd_t it;
        it.cmd = cofr_pkg::CMD_START;
        it.cx = cx;
        it.cy = cy;
        it.r = r;
        it.lc = lc;
        it.fc = fc;
        it.fe = fe;
        send_item(it);
    endtask

    // step beats carry junk in the unused fields
    task automatic send_step();
        circle_cmd_t it;
        it = CMD_BITS'({$urandom, $urandom});
        it.cmd = cofr_pkg::CMD_STEP;
        send_item(it);
    endtask

    task automatic run_until_idle(int cap);
        int n;
        n = 0;
        while (trace_phase != cofr_pkg::PH_IDLE && n < cap)
        begin
            send_step();
            n++;
        end
    endtask

    // drop valid and let every expected pixel come out
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [cofr_pkg::CFG_INDEX_W-1:0] idx,
                             logic [cofr_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == cofr_pkg::REG_COLUMNS)
            bound_cols = int'(value);
        else if (idx == cofr_pkg::REG_LINES)
            bound_lines = int'(value);
    endtask

    task automatic write_bounds(logic [cofr_pkg::CFG_DATA_W-1:0] cols,
                                logic [cofr_pkg::CFG_DATA_W-1:0] rows);
        settle();
        write_reg(cofr_pkg::REG_COLUMNS, cols);
        write_reg(cofr_pkg::REG_LINES, rows);
        cfg_valid <= 1'b0;
    endtask

    // one random burst: mostly complete circles, plus rejects, idle steps and aborts
    task automatic random_sequence();
        int pick;
        int r;
        int cap;
        logic [cofr_pkg::COORD_W-1:0] cx;
        logic [cofr_pkg::COORD_W-1:0] cy;
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            cx = cofr_pkg::COORD_W'($urandom_range(0, bound_cols));
            cy = cofr_pkg::COORD_W'($urandom_range(0, bound_lines - 1));
            pick = $urandom_range(0, 99);
            // big fills take thousands of steps, so those are cut short by the next start
            if (pick < 80)
            begin
                r = $urandom_range(0, 8);
                cap = 400;
            end
            else if (pick < 95)
            begin
                r = $urandom_range(9, 24);
                cap = $urandom_range(10, 40);
            end
            else
            begin
                r = $urandom_range(25, 255);
                cap = $urandom_range(1, 6);
            end
            send_start(cx, cy, r[cofr_pkg::RADIUS_W-1:0],
                       cofr_pkg::COLOR_W'($urandom_range(0, 65535)),
                       cofr_pkg::COLOR_W'($urandom_range(0, 65535)),
                       1'($urandom_range(0, 1)));
            run_until_idle(cap);
        end
        else if (pick < 84)
        begin
            // center out of bounds
            if (bound_cols < 255 && $urandom_range(0, 1) == 1)
            begin
                cx = cofr_pkg::COORD_W'($urandom_range(bound_cols + 1, 255));
                cy = cofr_pkg::COORD_W'($urandom_range(0, 255));
            end
            else
            begin
                cx = cofr_pkg::COORD_W'($urandom_range(0, 255));
                cy = cofr_pkg::COORD_W'($urandom_range(bound_lines, 255));
            end
            send_start(cx, cy, cofr_pkg::RADIUS_W'($urandom_range(0, 255)),
                       cofr_pkg::COLOR_W'($urandom_range(0, 65535)),
                       cofr_pkg::COLOR_W'($urandom_range(0, 65535)),
                       1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 2)) send_step();
        end
        else if (pick < 94)
            send_step();
        else
        begin
            // circle left unfinished, the next start aborts it
            cx = cofr_pkg::COORD_W'($urandom_range(0, bound_cols));
            cy = cofr_pkg::COORD_W'($urandom_range(0, bound_lines - 1));
            send_start(cx, cy, cofr_pkg::RADIUS_W'($urandom_range(0, 30)),
                       cofr_pkg::COLOR_W'($urandom_range(0, 65535)),
                       cofr_pkg::COLOR_W'($urandom_range(0, 65535)), 1'b1);
            run_until_idle($urandom_range(1, 4));
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_idle_step();
        send_step();
    endtask

    // zero radius: eight points at the center, never a fill pass
    task automatic test_zero_radius();
        send_start(8'd0, 8'd0, 8'd0, 16'hFFFF, 16'h0000, 1'b1);
        run_until_idle(4);
        send_step();
    endtask

    // centers right on the accept limits, then just past them
    task automatic test_clip_edges();
        send_start(cofr_pkg::COLUMNS_RESET, cofr_pkg::LINES_RESET - 8'd1, 8'd1, 16'h0000,
                   16'hFFFF, 1'b1);
        run_until_idle(8);
        send_start(cofr_pkg::COLUMNS_RESET + 8'd1, 8'd10, 8'd3, 16'h1234, 16'h4321, 1'b1);
        send_step();
        send_start(8'd10, cofr_pkg::LINES_RESET, 8'd3, 16'h1234, 16'h4321, 1'b1);
        send_step();
    endtask

    // largest radius interrupted by a new start, which then runs to the end with fill
    task automatic test_abort();
        send_start(8'd80, 8'd60, 8'd255, 16'hF800, 16'h07E0, 1'b1);
        send_step();
        send_step();
        send_start(8'd5, 8'd5, 8'd3, 16'hAAAA, 16'h5555, 1'b1);
        run_until_idle(20);
    endtask

    task automatic test_register_extremes();
        // zero row bound rejects every start
        write_bounds(8'd0, 8'd0);
        send_start(8'd0, 8'd0, 8'd2, 16'h00FF, 16'hFF00, 1'b1);
        send_step();
        // full bounds, circles hanging off the far and near edges
        write_bounds(8'd255, 8'd255);
        send_start(8'd255, 8'd254, 8'd2, 16'h7BEF, 16'h8410, 1'b1);
        run_until_idle(20);
        send_start(8'd0, 8'd0, 8'd4, 16'h0F0F, 16'hF0F0, 1'b0);
        run_until_idle(20);
    endtask

    task automatic test_random_stretch(int gap_pct, int stall,
                                       logic [cofr_pkg::CFG_DATA_W-1:0] cols,
                                       logic [cofr_pkg::CFG_DATA_W-1:0] rows, int count);
        int goal;
        write_bounds(cols, rows);
        send_gap_pct = gap_pct;
        stall_pct = stall;
        goal = items_sent + count;
        while (items_sent < goal)
            random_sequence();
    endtask

    // receiver goes quiet while steps keep coming, so the input has to stall
    task automatic test_backpressure();
        settle();
        hold_off_requests++;
        send_start(8'd80, 8'd60, 8'd6, 16'hC0DE, 16'hBEEF, 1'b1);
        run_until_idle(400);
        send_step();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= cofr_pkg::REG_COLUMNS;
        cfg_data <= '0;
        in_valid <= 1'b0;
        command <= cofr_pkg::CMD_START;
        center_x <= '0;
        center_y <= '0;
        radius <= '0;
        line_color <= '0;
        fill_color <= '0;
        fill_enable <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_step();
        test_zero_radius();
        test_clip_edges();
        test_abort();
        test_register_extremes();
        test_random_stretch(26, 84, 8'd255, 8'd255, 120);
        test_random_stretch(84, 26, cofr_pkg::CFG_DATA_W'($urandom_range(8, 250)),
                            cofr_pkg::CFG_DATA_W'($urandom_range(8, 250)), 120);
        test_random_stretch(0, 0, cofr_pkg::COLUMNS_RESET, cofr_pkg::LINES_RESET, 120);
        test_backpressure();

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
sv/cofr_pkg.sv
sv/circle_outline_fill_rasterizer.sv
sv/cofr_checker.sv
verif/circle_outline_fill_rasterizer_test.sv
